>>> rtl/bbc_pkg.sv
// Shared constants, codes and control types of the block buffer cache.
package bbc_pkg;

    localparam int ENTRIES = 30;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int AGE_W   = IDX_W;
    localparam int CNT_W   = 8;
    localparam int ENTRY_W = 5;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 3;
    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX   = 8'hFF;
    localparam logic [BLK_W-1:0] LIMIT_RESET = 32'd2000;

    localparam logic [MODE_W-1:0] MODE_READ    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PIN     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNPIN   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FREE  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_REF  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PICK,
        S_COMMIT,
        S_SLOT,
        S_AGE,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DECODE,
        CMD_SCAN,
        CMD_PICK,
        CMD_COMMIT,
        CMD_SLOT,
        CMD_AGE,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic read_go;
        logic slot_go;
        logic idx_last;
        logic need_age;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/bbc_ctrl.sv
// Sequencer of the block buffer cache: steps the datapath through each request.
module bbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bbc_pkg::dp_status_t dp_st,
    output bbc_pkg::cmd_t       cmd
);

    bbc_pkg::state_t state_reg;
    bbc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = bbc_pkg::CMD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            bbc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = bbc_pkg::CMD_LOAD;
                    state_next = bbc_pkg::S_DECODE;
                end
            end
            bbc_pkg::S_DECODE:
            begin
                cmd = bbc_pkg::CMD_DECODE;
                if (dp_st.read_go)
                begin
                    state_next = bbc_pkg::S_SCAN;
                end
                else if (dp_st.slot_go)
                begin
                    state_next = bbc_pkg::S_SLOT;
                end
                else
                begin
                    state_next = bbc_pkg::S_OUT;
                end
            end
            bbc_pkg::S_SCAN:
            begin
                cmd = bbc_pkg::CMD_SCAN;
                if (dp_st.idx_last)
                begin
                    state_next = bbc_pkg::S_PICK;
                end
            end
            bbc_pkg::S_PICK:
            begin
                cmd        = bbc_pkg::CMD_PICK;
                state_next = bbc_pkg::S_COMMIT;
            end
            bbc_pkg::S_COMMIT:
            begin
                cmd        = bbc_pkg::CMD_COMMIT;
                state_next = bbc_pkg::S_OUT;
            end
            bbc_pkg::S_SLOT:
            begin
                cmd        = bbc_pkg::CMD_SLOT;
                state_next = dp_st.need_age ? bbc_pkg::S_AGE : bbc_pkg::S_OUT;
            end
            bbc_pkg::S_AGE:
            begin
                cmd = bbc_pkg::CMD_AGE;
                if (dp_st.idx_last)
                begin
                    state_next = bbc_pkg::S_OUT;
                end
            end
            bbc_pkg::S_OUT:
            begin
                if (dp_st.out_free)
                begin
                    cmd        = bbc_pkg::CMD_EMIT;
                    state_next = bbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bbc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/bbc_dp.sv
// Datapath of the block buffer cache: entry store, scan trackers and result register.
module bbc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbc_pkg::cmd_t                 cmd,
    output bbc_pkg::dp_status_t           dp_st,
    input  logic                          cfg_we,
    input  logic [bbc_pkg::BLK_W-1:0]     cfg_wdata,
    input  logic [bbc_pkg::MODE_W-1:0]    mode,
    input  logic [bbc_pkg::DEV_W-1:0]     req_dev,
    input  logic [bbc_pkg::BLK_W-1:0]     req_blk,
    input  logic [bbc_pkg::ENTRY_W-1:0]   slot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bbc_pkg::ENTRY_W-1:0]   entry,
    output logic                          need_load,
    output logic                          do_write,
    output logic [bbc_pkg::STAT_W-1:0]    status
);

    // entry store
    logic [bbc_pkg::DEV_W-1:0] tag_dev_reg   [bbc_pkg::ENTRIES];
    logic [bbc_pkg::BLK_W-1:0] tag_blk_reg   [bbc_pkg::ENTRIES];
    logic                      valid_reg     [bbc_pkg::ENTRIES];
    logic [bbc_pkg::CNT_W-1:0] count_reg     [bbc_pkg::ENTRIES];
    logic [bbc_pkg::AGE_W-1:0] age_reg       [bbc_pkg::ENTRIES];

    logic [bbc_pkg::BLK_W-1:0]   limit_reg;
    logic [bbc_pkg::MODE_W-1:0]  mode_reg;
    logic [bbc_pkg::DEV_W-1:0]   dev_reg;
    logic [bbc_pkg::BLK_W-1:0]   blk_reg;
    logic [bbc_pkg::ENTRY_W-1:0] slot_reg;
    logic [bbc_pkg::IDX_W-1:0]   idx_reg;

    logic                        hit_found_reg;
    logic [bbc_pkg::IDX_W-1:0]   hit_idx_reg;
    logic [bbc_pkg::AGE_W-1:0]   hit_age_reg;
    logic                        vic_found_reg;
    logic [bbc_pkg::IDX_W-1:0]   vic_idx_reg;
    logic [bbc_pkg::AGE_W-1:0]   vic_age_reg;
    logic [bbc_pkg::AGE_W-1:0]   old_age_reg;
    logic [bbc_pkg::IDX_W-1:0]   tgt_reg;

    logic [bbc_pkg::ENTRY_W-1:0] res_entry_reg;
    logic                        res_nl_reg;
    logic                        res_dw_reg;
    logic [bbc_pkg::STAT_W-1:0]  res_stat_reg;

    logic                        out_valid_reg;
    logic [bbc_pkg::ENTRY_W-1:0] out_entry_reg;
    logic                        out_nl_reg;
    logic                        out_dw_reg;
    logic [bbc_pkg::STAT_W-1:0]  out_stat_reg;

    // current entry at the single access pointer
    logic [bbc_pkg::DEV_W-1:0] rd_dev;
    logic [bbc_pkg::BLK_W-1:0] rd_blk;
    logic                      rd_valid;
    logic [bbc_pkg::CNT_W-1:0] rd_count;
    logic [bbc_pkg::AGE_W-1:0] rd_age;
    logic                      tag_match;
    logic                      slot_in_range;
    logic                      mode_slot_op;

    assign rd_dev   = tag_dev_reg[idx_reg];
    assign rd_blk   = tag_blk_reg[idx_reg];
    assign rd_valid = valid_reg[idx_reg];
    assign rd_count = count_reg[idx_reg];
    assign rd_age   = age_reg[idx_reg];

    assign tag_match     = (rd_dev == dev_reg) && (rd_blk == blk_reg);
    assign slot_in_range = (32'(slot_reg) < 32'(bbc_pkg::ENTRIES));

    always_comb
    begin
        mode_slot_op = mode_reg inside {[bbc_pkg::MODE_WRITE:bbc_pkg::MODE_UNPIN]};
    end

    assign dp_st.read_go  = (mode_reg == bbc_pkg::MODE_READ) && (blk_reg < limit_reg);
    assign dp_st.slot_go  = mode_slot_op && slot_in_range;
    assign dp_st.idx_last = (idx_reg == bbc_pkg::IDX_W'(bbc_pkg::ENTRIES - 1));
    assign dp_st.need_age = (mode_reg == bbc_pkg::MODE_RELEASE) && (rd_count == 8'd1);
    assign dp_st.out_free = !out_valid_reg || out_ready;

    // store, request and tracker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bbc_pkg::ENTRIES; i++)
            begin
                tag_dev_reg[i] <= '0;
                tag_blk_reg[i] <= '0;
                valid_reg[i]   <= 1'b0;
                count_reg[i]   <= '0;
                age_reg[i]     <= bbc_pkg::AGE_W'(bbc_pkg::ENTRIES - 1 - i);
            end
            limit_reg     <= bbc_pkg::LIMIT_RESET;
            idx_reg       <= '0;
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            case (cmd)
                bbc_pkg::CMD_DECODE:
                begin
                    idx_reg       <= dp_st.read_go ? '0 : bbc_pkg::IDX_W'(slot_reg);
                    hit_found_reg <= 1'b0;
                    vic_found_reg <= 1'b0;
                end
                bbc_pkg::CMD_SCAN:
                begin
                    // most recent match wins; least recent free entry is the victim
                    if (tag_match && (!hit_found_reg || rd_age < hit_age_reg))
                    begin
                        hit_found_reg <= 1'b1;
                    end
                    if (rd_count == '0 && (!vic_found_reg || rd_age > vic_age_reg))
                    begin
                        vic_found_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                bbc_pkg::CMD_PICK:
                begin
                    idx_reg <= hit_found_reg ? hit_idx_reg : vic_idx_reg;
                end
                bbc_pkg::CMD_COMMIT:
                begin
                    if (hit_found_reg)
                    begin
                        if (rd_count != bbc_pkg::COUNT_MAX)
                        begin
                            count_reg[idx_reg] <= rd_count + 1'b1;
                            valid_reg[idx_reg] <= 1'b1;
                        end
                    end
                    else if (vic_found_reg)
                    begin
                        tag_dev_reg[idx_reg] <= dev_reg;
                        tag_blk_reg[idx_reg] <= blk_reg;
                        count_reg[idx_reg]   <= 8'd1;
                        valid_reg[idx_reg]   <= 1'b1;
                    end
                end
                bbc_pkg::CMD_SLOT:
                begin
                    case (mode_reg)
                        bbc_pkg::MODE_RELEASE, bbc_pkg::MODE_UNPIN:
                        begin
                            if (rd_count != '0)
                            begin
                                count_reg[idx_reg] <= rd_count - 1'b1;
                            end
                        end
                        bbc_pkg::MODE_PIN:
                        begin
                            if (rd_count != bbc_pkg::COUNT_MAX)
                            begin
                                count_reg[idx_reg] <= rd_count + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    idx_reg <= '0;
                end
                bbc_pkg::CMD_AGE:
                begin
                    // advance every rank younger than the released one, front the target
                    if (idx_reg == tgt_reg)
                    begin
                        age_reg[idx_reg] <= '0;
                    end
                    else if (rd_age < old_age_reg)
                    begin
                        age_reg[idx_reg] <= rd_age + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            bbc_pkg::CMD_LOAD:
            begin
                mode_reg <= mode;
                dev_reg  <= req_dev;
                blk_reg  <= req_blk;
                slot_reg <= slot;
            end
            bbc_pkg::CMD_DECODE:
            begin
                res_nl_reg <= 1'b0;
                res_dw_reg <= 1'b0;
                if (mode_reg == bbc_pkg::MODE_READ)
                begin
                    res_entry_reg <= '0;
                    res_stat_reg  <= bbc_pkg::STAT_RANGE;
                end
                else if (!mode_slot_op)
                begin
                    res_entry_reg <= '0;
                    res_stat_reg  <= bbc_pkg::STAT_OK;
                end
                else
                begin
                    res_entry_reg <= slot_reg;
                    res_stat_reg  <= bbc_pkg::STAT_NOT_REF;
                end
            end
            bbc_pkg::CMD_SCAN:
            begin
                if (tag_match && (!hit_found_reg || rd_age < hit_age_reg))
                begin
                    hit_idx_reg <= idx_reg;
                    hit_age_reg <= rd_age;
                end
                if (rd_count == '0 && (!vic_found_reg || rd_age > vic_age_reg))
                begin
                    vic_idx_reg <= idx_reg;
                    vic_age_reg <= rd_age;
                end
            end
            bbc_pkg::CMD_COMMIT:
            begin
                res_dw_reg <= 1'b0;
                if (hit_found_reg)
                begin
                    res_entry_reg <= bbc_pkg::ENTRY_W'(idx_reg);
                    if (rd_count == bbc_pkg::COUNT_MAX)
                    begin
                        res_nl_reg   <= 1'b0;
                        res_stat_reg <= bbc_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        res_nl_reg   <= !rd_valid;
                        res_stat_reg <= bbc_pkg::STAT_OK;
                    end
                end
                else if (vic_found_reg)
                begin
                    res_entry_reg <= bbc_pkg::ENTRY_W'(idx_reg);
                    res_nl_reg    <= 1'b1;
                    res_stat_reg  <= bbc_pkg::STAT_OK;
                end
                else
                begin
                    res_entry_reg <= '0;
                    res_nl_reg    <= 1'b0;
                    res_stat_reg  <= bbc_pkg::STAT_NO_FREE;
                end
            end
            bbc_pkg::CMD_SLOT:
            begin
                res_entry_reg <= slot_reg;
                res_nl_reg    <= 1'b0;
                res_dw_reg    <= 1'b0;
                res_stat_reg  <= bbc_pkg::STAT_OK;
                old_age_reg   <= rd_age;
                tgt_reg       <= idx_reg;
                case (mode_reg)
                    bbc_pkg::MODE_PIN:
                    begin
                        if (rd_count == bbc_pkg::COUNT_MAX)
                        begin
                            res_stat_reg <= bbc_pkg::STAT_OVERFLOW;
                        end
                    end
                    bbc_pkg::MODE_WRITE:
                    begin
                        if (rd_count == '0)
                        begin
                            res_stat_reg <= bbc_pkg::STAT_NOT_REF;
                        end
                        else
                        begin
                            res_dw_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        if (rd_count == '0)
                        begin
                            res_stat_reg <= bbc_pkg::STAT_NOT_REF;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd == bbc_pkg::CMD_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == bbc_pkg::CMD_EMIT)
        begin
            out_entry_reg <= res_entry_reg;
            out_nl_reg    <= res_nl_reg;
            out_dw_reg    <= res_dw_reg;
            out_stat_reg  <= res_stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign entry     = out_entry_reg;
    assign need_load = out_nl_reg;
    assign do_write  = out_dw_reg;
    assign status    = out_stat_reg;

endmodule

>>> rtl/block_buffer_cache_lru.sv
// Top level of the LRU disk block buffer cache with reference counts.
//
//  channel   direction  handshake             word
//  request   in         in_valid / in_ready   mode, req_dev, req_blk, slot
//  result    out        out_valid / out_ready entry, need_load, do_write, status
//  config    in         cfg_we (no wait)      cfg_wdata -> block limit
//
// A read below the block limit goes from acceptance to the result word through one
// decode step, one pass over all 30 entries through the single entry pointer, then
// pick and commit. Write, pin, unpin and most releases go through decode and slot; a
// read past the limit, a slot beyond the cache and an unused mode go from decode
// straight to output. A release that drops the count to zero adds a second pass over
// all entries to renumber the recency ranks. Reset clears every tag, count and valid
// bit at once and sets ranks to 29 down to 0; no clearing pass. One request is in
// flight at a time; a finished word waits in the output register and a stalled
// output holds the sequencer only at its final step.
module block_buffer_cache_lru (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bbc_pkg::MODE_W-1:0]    mode,
    input  logic [bbc_pkg::DEV_W-1:0]     req_dev,
    input  logic [bbc_pkg::BLK_W-1:0]     req_blk,
    input  logic [bbc_pkg::ENTRY_W-1:0]   slot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bbc_pkg::ENTRY_W-1:0]   entry,
    output logic                          need_load,
    output logic                          do_write,
    output logic [bbc_pkg::STAT_W-1:0]    status,
    input  logic                          cfg_we,
    input  logic [bbc_pkg::BLK_W-1:0]     cfg_wdata
);

    bbc_pkg::cmd_t       cmd;
    bbc_pkg::dp_status_t dp_st;

    // sequencer: one command per cycle while a request is in flight and the output is not stalled
    bbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .dp_st    (dp_st),
        .cmd      (cmd)
    );

    // entry store, scan trackers, limit register and output word
    bbc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .dp_st     (dp_st),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mode      (mode),
        .req_dev   (req_dev),
        .req_blk   (req_blk),
        .slot      (slot),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .entry     (entry),
        .need_load (need_load),
        .do_write  (do_write),
        .status    (status)
    );

endmodule
